FILE: hw/rtl/prpu_pkg.sv
// Package for the packed raw pixel unpacker: word types, job type and codes.
// Used by every module of the block; it depends on nothing else.
`default_nettype none

package prpu_pkg;

    // Unpack mode codes (any other code behaves as passthrough)
    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_RAW10 = 2'd1;
    localparam logic [1:0] MODE_RAW12 = 2'd2;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNPACK_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_PIXELS = 2'd1;

    // Group geometry: bytes held before the closing byte of a group
    localparam logic [2:0] HELD_RAW10 = 3'd4;
    localparam logic [2:0] HELD_RAW12 = 3'd2;
    localparam logic [2:0] HELD_PASS  = 3'd1;

    // Pixels produced by one closing byte
    localparam logic [2:0] PIX_RAW10 = 3'd4;
    localparam logic [2:0] PIX_RAW12 = 3'd2;
    localparam logic [2:0] PIX_PASS  = 3'd1;

    localparam int PIX_PER_JOB = 4;
    localparam int JOB_COUNT_W = 3;

    typedef logic [15:0] pixel_t;

    // Word on the byte input channel
    typedef struct packed {
        logic [7:0] raw_byte;
        logic       last_byte;
    } in_word_t;

    // Word on the pixel output channel
    typedef struct packed {
        pixel_t pixel_value;
        logic   pixel_valid;
        logic   frame_end;
        logic   frame_short;
    } out_word_t;

    // Work handed from the front to the back: up to four pixels and a marker
    typedef struct packed {
        logic [PIX_PER_JOB-1:0][15:0] pixels;
        logic [JOB_COUNT_W-1:0]       count;
        logic                         end_on_last;
        logic                         marker;
    } job_t;

    // Handshake between the front and the queue
    typedef struct packed {
        logic push;
        job_t job;
    } job_push_t;

endpackage

`default_nettype wire

FILE: hw/rtl/prpu_stream_if.sv
// Valid/ready stream interface carrying one word of a chosen type.
// Depends on nothing; the word types come from prpu_pkg at the point of use.
`default_nettype none

interface prpu_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/prpu_front.sv
// Front end: configuration registers, byte accept, group assembly, pixel
// extraction and frame pixel counting. Uses prpu_pkg and prpu_stream_if.
`default_nettype none

module prpu_front #(
    parameter int PIXEL_COUNT_BITS = 24
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_we,
    input  wire [prpu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire [prpu_pkg::CFG_DATA_W-1:0]  cfg_data,
    prpu_stream_if.sink                     raw_stream,
    input  wire                             queue_full,
    output prpu_pkg::job_push_t             job_out
);
    import prpu_pkg::*;

    localparam int CW = PIXEL_COUNT_BITS;

    logic [1:0]            unpack_mode_reg;
    logic [CFG_DATA_W-1:0] frame_pixels_reg;
    logic [31:0]           group_bytes_reg, group_bytes_next;
    logic [2:0]            group_pos_reg, group_pos_next;
    logic [CW-1:0]         emitted_reg, emitted_next;

    logic                  accept;
    logic                  cfg_hit;
    logic [CW+CFG_DATA_W-1:0] limit_ext;
    logic [CW-1:0]         limit;
    logic [CW-1:0]         remaining;
    logic [2:0]            cand;
    logic [2:0]            taken;
    logic                  marker;
    logic                  end_here;
    logic [PIX_PER_JOB-1:0][15:0] pix;
    logic [7:0]            b, b0, b1, b2, b3;
    logic                  last;
    job_t                  job;

    assign b    = raw_stream.payload.raw_byte;
    assign last = raw_stream.payload.last_byte;
    assign b0   = group_bytes_reg[7:0];
    assign b1   = group_bytes_reg[15:8];
    assign b2   = group_bytes_reg[23:16];
    assign b3   = group_bytes_reg[31:24];

    // A byte is taken whenever the queue has room for a job
    assign raw_stream.ready = !queue_full;
    assign accept           = raw_stream.valid && raw_stream.ready;
    assign cfg_hit = cfg_we && (cfg_index == CFG_UNPACK_MODE || cfg_index == CFG_FRAME_PIXELS);

    // Pixel count limit, cut or widened to the counter width
    assign limit_ext = {{CW{1'b0}}, frame_pixels_reg};
    assign limit     = limit_ext[CW-1:0];
    assign remaining = limit - emitted_reg;

    // Group assembly and pixel extraction
    always_comb
    begin
        cand             = 3'd0;
        pix              = '0;
        group_bytes_next = group_bytes_reg;
        group_pos_next   = group_pos_reg;
        case (unpack_mode_reg)
            MODE_RAW10:
            begin
                if (group_pos_reg >= HELD_RAW10)
                begin
                    cand             = PIX_RAW10;
                    pix[0]           = {6'd0, b1[1:0], b0};
                    pix[1]           = {6'd0, b2[3:0], b1[7:2]};
                    pix[2]           = {6'd0, b3[5:0], b2[7:4]};
                    pix[3]           = {6'd0, b, b3[7:6]};
                    group_bytes_next = '0;
                    group_pos_next   = '0;
                end
                else
                begin
                    group_bytes_next = group_bytes_reg | ({24'd0, b} << {group_pos_reg[1:0], 3'd0});
                    group_pos_next   = group_pos_reg + 3'd1;
                end
            end
            MODE_RAW12:
            begin
                if (group_pos_reg >= HELD_RAW12)
                begin
                    cand             = PIX_RAW12;
                    pix[0]           = {4'd0, b1[3:0], b0};
                    pix[1]           = {4'd0, b, b1[7:4]};
                    group_bytes_next = '0;
                    group_pos_next   = '0;
                end
                else
                begin
                    group_bytes_next = group_bytes_reg | ({24'd0, b} << {group_pos_reg[1:0], 3'd0});
                    group_pos_next   = group_pos_reg + 3'd1;
                end
            end
            default:
            begin
                if (group_pos_reg >= HELD_PASS)
                begin
                    cand             = PIX_PASS;
                    pix[0]           = {b, b0};
                    group_bytes_next = '0;
                    group_pos_next   = '0;
                end
                else if (last)
                begin
                    cand   = PIX_PASS;
                    pix[0] = {8'd0, b};
                end
                else
                begin
                    group_bytes_next = {24'd0, b};
                    group_pos_next   = 3'd1;
                end
            end
        endcase
    end

    // Clip the group's pixels to what is left of the frame
    always_comb
    begin
        if (remaining < {{(CW-3){1'b0}}, cand})
        begin
            taken = remaining[2:0];
        end
        else
        begin
            taken = cand;
        end
        end_here     = (taken != 3'd0) && (remaining == {{(CW-3){1'b0}}, taken});
        marker       = last && (remaining != {{(CW-3){1'b0}}, taken});
        emitted_next = emitted_reg + {{(CW-3){1'b0}}, taken};
    end

    always_comb
    begin
        job.pixels      = pix;
        job.count       = taken;
        job.end_on_last = end_here;
        job.marker      = marker;
        job_out.job     = job;
        job_out.push    = accept && ((taken != 3'd0) || marker);
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unpack_mode_reg  <= MODE_PASS;
            frame_pixels_reg <= CFG_DATA_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_UNPACK_MODE)
            begin
                unpack_mode_reg <= cfg_data[1:0];
            end
            else if (cfg_index == CFG_FRAME_PIXELS)
            begin
                frame_pixels_reg <= cfg_data;
            end
        end
    end

    // Frame state: cleared by a register write and after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_bytes_reg <= '0;
            group_pos_reg   <= '0;
            emitted_reg     <= '0;
        end
        else if (cfg_hit || (accept && last))
        begin
            group_bytes_reg <= '0;
            group_pos_reg   <= '0;
            emitted_reg     <= '0;
        end
        else if (accept)
        begin
            group_bytes_reg <= group_bytes_next;
            group_pos_reg   <= group_pos_next;
            emitted_reg     <= emitted_next;
        end
    end

    // The frame counter never passes the limit
    a_emitted_le_limit: assert property (@(posedge clk) disable iff (!rst_n)
        emitted_reg <= limit)
        else $error("pixel counter passed the frame limit");

    // A group never holds more than four bytes
    a_group_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        group_pos_reg <= HELD_RAW10)
        else $error("group position out of range");

endmodule

`default_nettype wire

FILE: hw/rtl/prpu_queue.sv
// Short job queue between the front end and the output sequencer.
// Uses prpu_pkg for the job type.
`default_nettype none

module prpu_queue #(
    parameter int DEPTH = 4
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  prpu_pkg::job_push_t job_in,
    output logic                full,
    input  wire                 pop,
    output prpu_pkg::job_t      head,
    output logic                empty
);
    import prpu_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = job_in.push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Job storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= job_in.job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // The front end must not offer a job while the queue is full
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(job_in.push && full))
        else $error("job pushed into a full queue");

    // Pointers agree with the fill count
    a_ptrs_match_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_W'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

FILE: hw/rtl/prpu_back.sv
// Output sequencer: walks each queued job one result per cycle into the
// output register while it is free. Uses prpu_pkg and prpu_stream_if.
`default_nettype none

module prpu_back (
    input  wire            clk,
    input  wire            rst_n,
    input  prpu_pkg::job_t head,
    input  wire            empty,
    output logic           pop,
    prpu_stream_if.source  pixel_stream
);
    import prpu_pkg::*;

    logic [JOB_COUNT_W-1:0] idx_reg, idx_next;
    logic [JOB_COUNT_W-1:0] total;
    logic                   out_valid_reg, out_valid_next;
    out_word_t              out_word_reg, out_word_next;
    logic                   load;
    logic                   last_result;

    assign total       = head.count + {{(JOB_COUNT_W-1){1'b0}}, head.marker};
    assign last_result = (idx_reg == total - JOB_COUNT_W'(1));
    assign load        = !empty && (!out_valid_reg || pixel_stream.ready);
    assign pop         = load && last_result;

    assign pixel_stream.valid   = out_valid_reg;
    assign pixel_stream.payload = out_word_reg;

    // Pick the next result of the head job
    always_comb
    begin
        out_word_next  = out_word_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !pixel_stream.ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (idx_reg < head.count)
            begin
                out_word_next.pixel_value = head.pixels[idx_reg[1:0]];
                out_word_next.pixel_valid = 1'b1;
                out_word_next.frame_end   = head.end_on_last &&
                                            (idx_reg == head.count - JOB_COUNT_W'(1));
                out_word_next.frame_short = 1'b0;
            end
            else
            begin
                out_word_next.pixel_value = '0;
                out_word_next.pixel_valid = 1'b0;
                out_word_next.frame_end   = 1'b1;
                out_word_next.frame_short = 1'b1;
            end
            idx_next = last_result ? '0 : idx_reg + JOB_COUNT_W'(1);
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // A part-walked job is always still at the head of the queue
    a_idx_with_job: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> (!empty && idx_reg < total))
        else $error("result index outside the head job");

    // A marker word always closes a frame as short
    a_marker_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_word_reg.pixel_valid) |->
        (out_word_reg.frame_end && out_word_reg.frame_short && out_word_reg.pixel_value == '0))
        else $error("malformed truncation marker");

endmodule

`default_nettype wire

FILE: hw/rtl/packed_raw_pixel_unpacker_core.sv
// Top level of the packed raw pixel unpacker: front end, job queue, sequencer.
// Uses prpu_pkg, prpu_stream_if, prpu_front, prpu_queue and prpu_back.
//
//  Channel        Direction  Word                          Handshake
//  raw_stream     in         raw_byte[7:0], last_byte      valid/ready
//  pixel_stream   out        pixel_value[15:0], pixel_valid,
//                            frame_end, frame_short        valid/ready
//  cfg_*          in         cfg_index[1:0], cfg_data[23:0] cfg_we, no wait
//
// One byte is accepted per cycle while the job queue has room; results leave at
// one word per cycle from the output register when not stalled, keeping pace
// with the bytes (five give four pixels in 10-bit mode, three give two in 12-bit).
// Only a stalled output or a burst of markers fills the queue and holds bytes back.
// A group's results pass through a queue slot and then the output register.
// Reset clears the frame state and sets passthrough mode with a one-pixel frame.
// An output stall backs up through the queue of QUEUE_DEPTH jobs to raw_stream.
`default_nettype none

module packed_raw_pixel_unpacker_core #(
    parameter int PIXEL_COUNT_BITS = 24,
    parameter int QUEUE_DEPTH      = 4
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_we,
    input  wire [prpu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire [prpu_pkg::CFG_DATA_W-1:0]  cfg_data,
    prpu_stream_if.sink                     raw_stream,
    prpu_stream_if.source                   pixel_stream
);
    import prpu_pkg::*;

    job_push_t job_push;
    job_t      head_job;
    logic      queue_full;
    logic      queue_empty;
    logic      queue_pop;

    prpu_front #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .raw_stream (raw_stream),
        .queue_full (queue_full),
        .job_out    (job_push)
    );

    prpu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .job_in (job_push),
        .full   (queue_full),
        .pop    (queue_pop),
        .head   (head_job),
        .empty  (queue_empty)
    );

    prpu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_job),
        .empty        (queue_empty),
        .pop          (queue_pop),
        .pixel_stream (pixel_stream)
    );

endmodule

`default_nettype wire
